// ----- rtl/core/packbits_bitmap_crop_decoder_core_assert.svh -----
// Assertion macros for the packbits bitmap crop decoder core.
`ifndef PACKBITS_BITMAP_CROP_DECODER_CORE_ASSERT_SVH
`define PACKBITS_BITMAP_CROP_DECODER_CORE_ASSERT_SVH

// Checks that a property holds at every clock edge outside reset.
`define PBCD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("packbits decoder core check failed");

// Checks that a condition holds in the cycle after a trigger.
`define PBCD_ASSERT_NEXT(lbl, trig, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cond)) \
    else $error("packbits decoder core sequence check failed");

`endif

// ----- rtl/core/pbcd_pkg.sv -----
// Shared types and constants of the packbits bitmap crop decoder core.
package pbcd_pkg;

  localparam int LINE_BITS_DEF     = 576;
  localparam int IMAGE_LINES_DEF   = 720;
  localparam int WINDOW_WIDTH_DEF  = 512;
  localparam int WINDOW_HEIGHT_DEF = 160;

  localparam int CFG_DATA_W = 11;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_X_OFFSET = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_OFFSET = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INVERT   = 2'd2;

  localparam int OQ_DEPTH = 4;
  localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
  localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

  typedef struct packed {
    logic [7:0] out_byte;
    logic [7:0] copies;
    logic       is_padding;
    logic       last;
  } result_t;

  typedef struct packed {
    logic [1:0] cnt;
    result_t    r0;
    result_t    r1;
  } push_t;

endpackage

// ----- rtl/core/pbcd_decode.sv -----
// Input register, decode state and crop logic that turns one code byte into results.
module pbcd_decode import pbcd_pkg::*; #(
  parameter int LINE_BITS     = LINE_BITS_DEF,
  parameter int IMAGE_LINES   = IMAGE_LINES_DEF,
  parameter int WINDOW_WIDTH  = WINDOW_WIDTH_DEF,
  parameter int WINDOW_HEIGHT = WINDOW_HEIGHT_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [7:0]            code_byte_i,
  input  logic                  room_i,
  output push_t                 push_o
);

  localparam int RUN_MAX = 129;
  localparam int LB_W    = $clog2(LINE_BITS + 8 * RUN_MAX + 8);
  localparam int XW      = LB_W + 1;
  localparam int CW      = LB_W + 3;
  localparam int YW      = $clog2(IMAGE_LINES + 1);
  localparam int YCW     = ((YW > CFG_DATA_W) ? YW : CFG_DATA_W) + 2;

  localparam logic [1:0] MODE_HEADER  = 2'd0;
  localparam logic [1:0] MODE_RUN     = 2'd1;
  localparam logic [1:0] MODE_LITERAL = 2'd2;

  localparam logic signed [CW-1:0]  WW_S = CW'(WINDOW_WIDTH);
  localparam logic signed [YCW-1:0] WH_S = YCW'(WINDOW_HEIGHT);

  logic signed [CFG_DATA_W-1:0] xo_q, yo_q;
  logic                         inv_q;
  logic                         in_vld_q;
  logic [7:0]                   byte_q;
  logic [1:0]                   mode_q, mode_d;
  logic [7:0]                   bl_q, bl_d;
  logic [LB_W-1:0]              lb_q, lb_d;
  logic [XW-1:0]                x_q, x_d;
  logic [YW-1:0]                y_q, y_d;
  logic                         done_q, done_d;

  logic                  fire, is_run, is_lit;
  logic signed [CW-1:0]  xo_s, x_s, lim_s, hi_d, lo_d, xn_s, pad_d;
  logic [CW-1:0]         hi_c, lo_c, cnt_e, top_c, n_c, pad_u;
  logic signed [YCW-1:0] y_s, yo_s, ylo_d, yhi_d;
  logic                  row_in, col_in, run_hit, lit_hit, data_hit, pad_hit;
  logic [10:0]           adv;
  logic [XW-1:0]         xn;
  logic [LB_W-1:0]       lbn;
  logic                  line_end, pkt_done, finish;
  logic [7:0]            data_val, run_n, pad_n;
  result_t               d_res, p_res;

  assign fire       = in_vld_q & room_i;
  assign in_stall_o = in_vld_q & ~room_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      xo_q  <= '0;
      yo_q  <= '0;
      inv_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_X_OFFSET: xo_q  <= cfg_data_i;
        CFG_Y_OFFSET: yo_q  <= cfg_data_i;
        CFG_INVERT:   inv_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (!in_vld_q || fire) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_vld_q || fire) begin
      byte_q <= code_byte_i;
    end
  end

  assign is_run = (mode_q == MODE_RUN);
  assign is_lit = (mode_q == MODE_LITERAL);

  // Window bounds in signed arithmetic wide enough for every offset.
  assign xo_s  = {{(CW - CFG_DATA_W){xo_q[CFG_DATA_W-1]}}, xo_q};
  assign x_s   = {{(CW - XW){1'b0}}, x_q};
  assign lim_s = WW_S + xo_s;
  assign hi_d  = lim_s - x_s;
  assign lo_d  = xo_s - x_s;

  assign y_s    = {{(YCW - YW){1'b0}}, y_q};
  assign yo_s   = {{(YCW - CFG_DATA_W){yo_q[CFG_DATA_W-1]}}, yo_q};
  assign ylo_d  = y_s - yo_s;
  assign yhi_d  = y_s - (WH_S + yo_s);
  assign row_in = !ylo_d[YCW-1] && yhi_d[YCW-1];

  assign col_in = (lo_d[CW-1] || lo_d == '0) && !hi_d[CW-1] && hi_d != '0;

  // The run covers byte indexes from lo_c up to min(count, hi_c) inside the window.
  assign hi_c  = (!hi_d[CW-1] && hi_d != '0) ? ((CW'(hi_d) + CW'(7)) >> 3) : '0;
  assign lo_c  = (!lo_d[CW-1] && lo_d != '0) ? ((CW'(lo_d) + CW'(7)) >> 3) : '0;
  assign cnt_e = CW'(bl_q);
  assign top_c = (hi_c < cnt_e) ? hi_c : cnt_e;
  assign n_c   = (top_c > lo_c) ? (top_c - lo_c) : '0;
  assign run_n = n_c[7:0];

  assign run_hit  = row_in && (n_c != '0);
  assign lit_hit  = row_in && col_in;
  assign data_hit = fire && !done_q && ((is_run && run_hit) || (is_lit && lit_hit));

  assign adv      = is_run ? {bl_q, 3'b000} : 11'd8;
  assign xn       = x_q + XW'(adv);
  assign lbn      = lb_q + LB_W'(adv);
  assign line_end = (lbn >= LB_W'(LINE_BITS));
  assign pkt_done = is_run || (is_lit && bl_q <= 8'd1);
  assign finish   = pkt_done && line_end;

  assign xn_s    = {{(CW - XW){1'b0}}, xn};
  assign pad_d   = lim_s - xn_s;
  assign pad_u   = CW'(pad_d);
  assign pad_n   = pad_u[10:3] + 8'd1;
  assign pad_hit = fire && !done_q && finish && row_in && !pad_d[CW-1];

  assign data_val = inv_q ? ~byte_q : byte_q;

  always_comb begin
    d_res            = '0;
    d_res.out_byte   = data_val;
    d_res.copies     = is_run ? run_n : 8'd1;
    d_res.is_padding = 1'b0;
    d_res.last       = !pad_hit;
    p_res            = '0;
    p_res.out_byte   = 8'd0;
    p_res.copies     = pad_n;
    p_res.is_padding = 1'b1;
    p_res.last       = 1'b1;
    push_o.cnt       = {1'b0, data_hit} + {1'b0, pad_hit};
    push_o.r0        = data_hit ? d_res : p_res;
    push_o.r1        = p_res;
  end

  always_comb begin
    mode_d = mode_q;
    bl_d   = bl_q;
    lb_d   = lb_q;
    x_d    = x_q;
    y_d    = y_q;
    done_d = done_q;
    if (fire && !done_q) begin
      case (mode_q)
        MODE_RUN: begin
          mode_d = MODE_HEADER;
          bl_d   = 8'd0;
          lb_d   = lbn;
          x_d    = xn;
        end
        MODE_LITERAL: begin
          lb_d = lbn;
          x_d  = xn;
          if (bl_q != 8'd0) begin
            bl_d = bl_q - 8'd1;
          end
          if (pkt_done) begin
            mode_d = MODE_HEADER;
          end
        end
        default: begin
          if (byte_q[7]) begin
            mode_d = MODE_RUN;
            bl_d   = 8'(9'd257 - {1'b0, byte_q});
          end else begin
            mode_d = MODE_LITERAL;
            bl_d   = byte_q + 8'd1;
          end
        end
      endcase
      if ((is_run || is_lit) && finish) begin
        x_d  = XW'(3);
        lb_d = '0;
        y_d  = y_q + YW'(1);
        if ((y_q + YW'(1)) >= YW'(IMAGE_LINES)) begin
          done_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_HEADER;
      bl_q   <= '0;
      lb_q   <= '0;
      x_q    <= '0;
      y_q    <= '0;
      done_q <= 1'b0;
    end else begin
      mode_q <= mode_d;
      bl_q   <= bl_d;
      lb_q   <= lb_d;
      x_q    <= x_d;
      y_q    <= y_d;
      done_q <= done_d;
    end
  end

endmodule

// ----- rtl/core/pbcd_out_fifo.sv -----
// Result queue that takes up to two results a cycle and hands out one unless out_stall_i is set.
module pbcd_out_fifo import pbcd_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  push_t               push_i,
  output logic [OQ_CNT_W-1:0] count_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output result_t             head_o
);

  result_t              mem_q [OQ_DEPTH];
  logic [OQ_PTR_W-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [OQ_CNT_W-1:0]  cnt_q, cnt_d;
  logic                 pop;

  assign pop         = (cnt_q != '0) && !out_stall_i;
  assign out_valid_o = (cnt_q != '0);
  assign head_o      = mem_q[rd_q];
  assign count_o     = cnt_q;

  assign wr_d  = wr_q + OQ_PTR_W'(push_i.cnt);
  assign rd_d  = rd_q + OQ_PTR_W'(pop);
  assign cnt_d = cnt_q + OQ_CNT_W'(push_i.cnt) - OQ_CNT_W'(pop);

  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) begin
      mem_q[wr_q] <= push_i.r0;
    end
    if (push_i.cnt == 2'd2) begin
      mem_q[wr_q + OQ_PTR_W'(1)] <= push_i.r1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// ----- rtl/core/packbits_bitmap_crop_decoder_core.sv -----
// Top level of the packbits bitmap crop decoder core.
//
// Compressed bitmap bytes enter on the input channel (in_valid_i, in_stall_o,
// code_byte_i) and cropped bitmap results leave on the output channel
// (out_valid_o, out_stall_i, out_byte_o, copies_o, is_padding_o, last_o).
// Each result means that out_byte_o is written copies_o times in a row, and
// last_o marks the final result caused by one input item.
// An input item is held in the input register, where its results are worked
// out and pushed into a four-entry result queue once the queue has room; its
// first result is then shown from the queue. One item is taken per cycle
// while the queue has room; an item that closes a line can give two results,
// and those leave one per cycle while out_stall_i is low. The input side
// stalls while the queue holds more than two results, so a stalled receiver
// fills the queue and then holds back the input. Reset clears the decode
// state, the queue and the offset and invert registers; the cfg port must
// write them only while the block is idle, which the block does not enforce.
`include "packbits_bitmap_crop_decoder_core_assert.svh"

module packbits_bitmap_crop_decoder_core import pbcd_pkg::*; #(
  parameter int LINE_BITS     = LINE_BITS_DEF,
  parameter int IMAGE_LINES   = IMAGE_LINES_DEF,
  parameter int WINDOW_WIDTH  = WINDOW_WIDTH_DEF,
  parameter int WINDOW_HEIGHT = WINDOW_HEIGHT_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [7:0]            code_byte_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [7:0]            out_byte_o,
  output logic [7:0]            copies_o,
  output logic                  is_padding_o,
  output logic                  last_o
);

  push_t               push;
  logic [OQ_CNT_W-1:0] oq_count;
  logic                room;
  result_t             head;

  assign room = (oq_count <= OQ_CNT_W'(OQ_DEPTH - 2));

  pbcd_decode #(
    .LINE_BITS     (LINE_BITS),
    .IMAGE_LINES   (IMAGE_LINES),
    .WINDOW_WIDTH  (WINDOW_WIDTH),
    .WINDOW_HEIGHT (WINDOW_HEIGHT)
  ) u_decode (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .code_byte_i (code_byte_i),
    .room_i      (room),
    .push_o      (push)
  );

  pbcd_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .count_o     (oq_count),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .head_o      (head)
  );

  assign out_byte_o   = head.out_byte;
  assign copies_o     = head.copies;
  assign is_padding_o = head.is_padding;
  assign last_o       = head.last;

  `PBCD_ASSERT(a_count_bound, oq_count <= OQ_CNT_W'(OQ_DEPTH))
  `PBCD_ASSERT(a_copies_nonzero, out_valid_o |-> (copies_o != 8'd0))
  `PBCD_ASSERT(a_pad_shape, (out_valid_o && is_padding_o) |-> (out_byte_o == 8'd0 && last_o))
  `PBCD_ASSERT_NEXT(a_full_hold, (oq_count == OQ_CNT_W'(OQ_DEPTH)) && out_stall_i, oq_count == OQ_CNT_W'(OQ_DEPTH))

endmodule

// ----- tb/packbits_bitmap_crop_decoder_core_tb.sv -----
// Self-checking testbench for the packbits bitmap crop decoder core.
module packbits_bitmap_crop_decoder_core_tb;
  import pbcd_pkg::*;

  typedef enum logic [1:0] {
    MODE_HEADER  = 2'd0,
    MODE_RUN     = 2'd1,
    MODE_LITERAL = 2'd2
  } decode_mode_e;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  localparam int RUN_SPAN      = 257;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int DRAIN_LIMIT   = 4000;
  localparam int SETTLE_CYCLES = 6;
  localparam int MAX_PRINTS    = 20;
  localparam int PHASE_ITEMS   = 85;
  localparam int FINAL_LINES   = 80;

  class crop_tracker;
    logic [CFG_DATA_W-1:0] x_offset_reg;
    logic [CFG_DATA_W-1:0] y_offset_reg;
    logic                  invert_reg;
    decode_mode_e          mode;
    int                    bytes_left;
    int                    line_bits;
    int                    x_pos;
    int                    y_pos;
    bit                    image_done;
    result_t               expected_q[$];
    result_t               fresh[$];
    int                    mismatches;
    int                    results_checked;
    int                    fills_checked;

    function new();
      x_offset_reg    = '0;
      y_offset_reg    = '0;
      invert_reg      = 1'b0;
      mode            = MODE_HEADER;
      bytes_left      = 0;
      line_bits       = 0;
      x_pos           = 0;
      y_pos           = 0;
      image_done      = 1'b0;
      mismatches      = 0;
      results_checked = 0;
      fills_checked   = 0;
    endfunction

    function int offset_value(logic [CFG_DATA_W-1:0] raw);
      return {{(32 - CFG_DATA_W){raw[CFG_DATA_W-1]}}, raw};
    endfunction

    function bit row_visible();
      int yo;
      yo = offset_value(y_offset_reg);
      return y_pos >= yo && y_pos < WINDOW_HEIGHT_DEF + yo;
    endfunction

    function bit col_visible(int x);
      int xo;
      xo = offset_value(x_offset_reg);
      return x >= xo && x < WINDOW_WIDTH_DEF + xo;
    endfunction

    function logic [7:0] data_value(logic [7:0] code);
      return invert_reg ? ~code : code;
    endfunction

    function void add_result(logic [7:0] value, int count, logic fill);
      result_t r;
      r.out_byte   = value;
      r.copies     = 8'(count);
      r.is_padding = fill;
      r.last       = 1'b0;
      fresh.push_back(r);
    endfunction

    // A line only ends once the packet that crossed its end has completed.
    function void close_full_line();
      int limit;
      if (line_bits < LINE_BITS_DEF) return;
      if (row_visible()) begin
        limit = WINDOW_WIDTH_DEF + offset_value(x_offset_reg);
        if (x_pos <= limit) add_result(8'h00, (limit - x_pos) / 8 + 1, 1'b1);
      end
      x_pos     = 3;
      line_bits = 0;
      y_pos++;
      if (y_pos >= IMAGE_LINES_DEF) image_done = 1'b1;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_X_OFFSET: x_offset_reg = data;
        CFG_Y_OFFSET: y_offset_reg = data;
        CFG_INVERT:   invert_reg = data[0];
        default: ;
      endcase
    endfunction

    function void take_code_byte(logic [7:0] code);
      int visible;
      int i;
      fresh.delete();
      if (image_done) return;
      case (mode)
        MODE_RUN: begin
          visible = 0;
          if (row_visible()) begin
            for (i = 0; i < bytes_left; i++) begin
              if (col_visible(x_pos + 8 * i)) visible++;
            end
          end
          if (visible > 0) add_result(data_value(code), visible, 1'b0);
          x_pos      += 8 * bytes_left;
          line_bits  += 8 * bytes_left;
          bytes_left  = 0;
          mode        = MODE_HEADER;
          close_full_line();
        end
        MODE_LITERAL: begin
          if (row_visible() && col_visible(x_pos)) add_result(data_value(code), 1, 1'b0);
          x_pos     += 8;
          line_bits += 8;
          if (bytes_left > 0) bytes_left--;
          if (bytes_left == 0) begin
            mode = MODE_HEADER;
            close_full_line();
          end
        end
        default: begin
          if (code[7]) begin
            bytes_left = RUN_SPAN - int'(code);
            mode       = MODE_RUN;
          end else begin
            bytes_left = int'(code) + 1;
            mode       = MODE_LITERAL;
          end
        end
      endcase
      if (fresh.size() > 0) fresh[fresh.size() - 1].last = 1'b1;
      foreach (fresh[j]) expected_q.push_back(fresh[j]);
    endfunction

    task report_mismatch(string msg);
      mismatches++;
      if (mismatches <= MAX_PRINTS) $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task check_result(logic [7:0] got_byte, logic [7:0] got_copies, logic got_fill,
                      logic got_last);
      result_t want;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result byte %02h copies %0d fill %0b last %0b",
                                  got_byte, got_copies, got_fill, got_last));
        return;
      end
      want = expected_q.pop_front();
      results_checked++;
      if (want.is_padding) fills_checked++;
      if (got_byte !== want.out_byte)
        report_mismatch($sformatf("result %0d out_byte %02h, expected %02h",
                                  results_checked, got_byte, want.out_byte));
      if (got_copies !== want.copies)
        report_mismatch($sformatf("result %0d copies %0d, expected %0d",
                                  results_checked, got_copies, want.copies));
      if (got_fill !== want.is_padding)
        report_mismatch($sformatf("result %0d is_padding %0b, expected %0b",
                                  results_checked, got_fill, want.is_padding));
      if (got_last !== want.last)
        report_mismatch($sformatf("result %0d last %0b, expected %0b",
                                  results_checked, got_last, want.last));
    endtask
  endclass

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;
  logic                  in_valid_i  = 1'b0;
  logic [7:0]            code_byte_i = '0;
  logic                  out_stall_i = 1'b0;
  logic                  in_stall_o;
  logic                  out_valid_o;
  logic [7:0]            out_byte_o;
  logic [7:0]            copies_o;
  logic                  is_padding_o;
  logic                  last_o;

  crop_tracker tracker = new();
  int          cycle_count   = 0;
  int          idle_pct      = 8;
  int          stall_pct     = 8;
  int          items_sent    = 0;
  int          settings_used = 0;

  packbits_bitmap_crop_decoder_core dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .code_byte_i  (code_byte_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_byte_o   (out_byte_o),
    .copies_o     (copies_o),
    .is_padding_o (is_padding_o),
    .last_o       (last_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding.", cycle_count,
               tracker.expected_q.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        tracker.check_result(out_byte_o, copies_o, is_padding_o, last_o);
      end
      out_stall_i <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  task automatic send_code(input logic [7:0] code);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    code_byte_i <= code;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    tracker.take_code_byte(code);
    items_sent++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    tracker.set_register(idx, data);
  endtask

  task automatic wait_drained();
    int waited;
    waited = 0;
    while (tracker.expected_q.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Registers change only once the input is quiet and every result is out or the drain wait times out.
  task automatic apply_setting(input logic [CFG_DATA_W-1:0] x_off,
                               input logic [CFG_DATA_W-1:0] y_off, input logic invert);
    in_valid_i <= 1'b0;
    wait_drained();
    write_reg(CFG_X_OFFSET, x_off);
    write_reg(CFG_Y_OFFSET, y_off);
    write_reg(CFG_INVERT, {10'($urandom), invert});
    write_reg(REG_UNUSED, 11'($urandom));
    cfg_we_i <= 1'b0;
    settings_used++;
  endtask

  task automatic send_packet();
    int kind;
    int length;
    int i;
    kind = $urandom_range(0, 99);
    if (kind < 10) begin
      send_code(8'($urandom));
    end else if (kind < 55) begin
      case ($urandom_range(0, 9))
        0, 1:    length = 129;
        2:       length = 2;
        3, 4, 5: length = $urandom_range(2, 129);
        default: length = $urandom_range(2, 17);
      endcase
      send_code(8'(RUN_SPAN - length));
      send_code(8'($urandom));
    end else begin
      case ($urandom_range(0, 19))
        0:       length = 128;
        1:       length = $urandom_range(1, 128);
        default: length = $urandom_range(1, 8);
      endcase
      send_code(8'(length - 1));
      for (i = 0; i < length; i++) send_code(8'($urandom));
    end
  endtask

  function automatic logic [CFG_DATA_W-1:0] rows_near_current();
    return CFG_DATA_W'(tracker.y_pos - int'($urandom_range(0, 150)));
  endfunction

  initial begin
    logic [7:0]            opening [15];
    logic [CFG_DATA_W-1:0] x_off;
    logic [CFG_DATA_W-1:0] y_off;
    int                    phase;
    int                    start_count;
    int                    i;

    opening = '{8'h00, 8'hFF, 8'h80, 8'hA5, 8'hFF, 8'h00, 8'h02, 8'h01,
                8'h80, 8'h7F, 8'hC0, 8'h5A, 8'h7F, 8'h00, 8'h3C};

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    apply_setting('0, '0, 1'b0);
    foreach (opening[k]) send_code(opening[k]);

    for (phase = 0; phase < 8; phase++) begin
      case (phase)
        0:       x_off = 11'h400;
        1:       x_off = 11'h3FF;
        2:       x_off = 11'(-512);
        3:       x_off = 11'd512;
        4:       x_off = 11'($urandom_range(64, 200));
        default: x_off = 11'($urandom);
      endcase
      case (phase)
        2:       y_off = 11'(-512);
        5:       y_off = 11'd512;
        6:       y_off = 11'h3FF;
        7:       y_off = 11'h400;
        default: y_off = rows_near_current();
      endcase
      apply_setting(x_off, y_off, phase[0]);
      idle_pct    = (phase == 4) ? 0 : 8;
      stall_pct   = (phase == 4) ? 0 : 8;
      start_count = items_sent;
      while (items_sent - start_count < PHASE_ITEMS && tracker.y_pos < 600) send_packet();
    end

    // Long runs close one line each, with the window around the current rows.
    apply_setting(11'($urandom_range(0, 200)), rows_near_current(), 1'($urandom));
    idle_pct  = 8;
    stall_pct = 8;
    for (i = 0; i < FINAL_LINES; i++) begin
      send_code(8'(RUN_SPAN - int'($urandom_range(72, 129))));
      send_code(8'($urandom));
    end
    in_valid_i <= 1'b0;

    wait_drained();
    repeat (10) @(posedge clk_i);
    if (tracker.expected_q.size() != 0) begin
      tracker.report_mismatch($sformatf("%0d expected results never arrived",
                                        tracker.expected_q.size()));
    end

    $display("Sent %0d code bytes under %0d window settings, through %0d image lines.",
             items_sent, settings_used, tracker.y_pos);
    $display("Checked %0d results, %0d of them line fills, with %0d mismatches.",
             tracker.results_checked, tracker.fills_checked, tracker.mismatches);
    if (tracker.mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
